/* rtl/core/lcdccb_pkg.sv */
// shared types, codes and constants of the segment lcd frame serializer
`default_nettype none

package lcdccb_pkg;

    localparam int STORE_DEPTH = 26;
    localparam int IDX_W       = 5;
    localparam int POS_W       = 7;
    localparam int FRAME_BITS  = 72;
    localparam int ADDR_BITS   = 8;

    localparam logic [7:0]       CCB_ADDRESS = 8'h82;
    localparam logic [POS_W-1:0] LAST_POS    = POS_W'(FRAME_BITS - 1);

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_START = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    // where the serial bit of a beat comes from
    typedef enum logic [1:0] {
        SRC_FIXED = 2'd0,
        SRC_STORE = 2'd1,
        SRC_CTRL  = 2'd2
    } src_t;

    // control carried from the read stage to the output stage
    typedef struct packed {
        src_t       src;
        logic [2:0] bit_sel;
        logic       fixed_bit;
        logic       chip_enable;
        logic [1:0] frame;
        logic       frame_end;
        logic       refresh_end;
    } bit_ctl_t;

    // first store byte of each frame's data, frames 1 and 3 start mid byte
    function automatic logic [IDX_W-1:0] frame_base(input logic [1:0] frame);
        logic [IDX_W-1:0] base;
        case (frame)
            2'd0:    base = 5'd0;
            2'd1:    base = 5'd6;
            2'd2:    base = 5'd13;
            default: base = 5'd19;
        endcase
        return base;
    endfunction

    // trailing frame code: 0001, 0010, 00000011 (frame 0 has none)
    function automatic logic tail_bit(input logic [1:0] frame, input logic [5:0] d);
        logic b;
        case (frame)
            2'd1:    b = (d == 6'd63);
            2'd2:    b = (d == 6'd62);
            2'd3:    b = (d >= 6'd62);
            default: b = 1'b0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/lcdccb_ifs.sv */
// command and serial bit channel interfaces of the frame serializer
`default_nettype none

interface lcdccb_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [4:0] byte_index;
    logic [7:0] byte_value;

    modport source (output valid, output cmd, output byte_index, output byte_value,
                    input ready);
    modport sink   (input valid, input cmd, input byte_index, input byte_value,
                    output ready);
endinterface

interface lcdccb_bit_if;
    logic       valid;
    logic       ready;
    logic       chip_enable;
    logic       data_bit;
    logic [1:0] frame_number;
    logic       frame_end;
    logic       refresh_end;

    modport source (output valid, output chip_enable, output data_bit,
                    output frame_number, output frame_end, output refresh_end,
                    input ready);
    modport sink   (input valid, input chip_enable, input data_bit,
                    input frame_number, input frame_end, input refresh_end,
                    output ready);
endinterface

`default_nettype wire

/* rtl/core/segment_lcd_ccb_frame_serializer.sv */
// segment lcd frame serializer: display store, refresh sequencer and bit output stage
//
// usage:
//   cmd_chan carries command beats: write a display byte (index 0..25, others
//   dropped), start a refresh of four 72-bit frames, or tick out one bit.
//   bit_chan carries one beat per tick while a refresh runs: the serial bit,
//   its chip-enable level (low for the 8 address bits 0x82, high for the 64
//   data bits), the frame number and frame / refresh end flags.
//   cfg_wr_en / cfg_wr_data load the control byte placed in frame 0's data.
// throughput and output timing:
//   one command beat per cycle while cmd_chan.ready is high; a tick's bit appears
//   on bit_chan in the cycle after it is taken, set by the registered store read.
// reset:
//   the store reads as zero until written (per-entry valid flops), the
//   control byte is zero and no refresh is running.
// stall:
//   the bit output register holds while bit_chan is stalled; cmd_chan keeps
//   taking beats as long as the output register is empty or drains that cycle.
//   start while a refresh runs is ignored, as are ticks while idle.
`default_nettype none

module segment_lcd_ccb_frame_serializer
    import lcdccb_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wr_en,
    input  wire logic [7:0]   cfg_wr_data,
    lcdccb_cmd_if.sink        cmd_chan,
    lcdccb_bit_if.source      bit_chan
);

    // display store memory, valid flags stand in for the reset clear
    logic [7:0]             store_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] vld_reg;
    logic [7:0]             rd_data_reg;
    logic                   rd_vld_reg;

    logic [7:0]       control_reg;
    logic             sending_reg;
    logic             sending_next;
    logic [1:0]       frame_reg;
    logic [1:0]       frame_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;

    bit_ctl_t s1_reg;
    bit_ctl_t s1_next;
    logic     s1_valid_reg;
    logic     s1_valid_next;

    logic             accept;
    logic             do_write;
    logic             do_tick;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [POS_W-1:0] d_full;
    logic [5:0]       d;
    logic [POS_W-1:0] e;
    logic [5:0]       ctrl_off;
    logic             in_store;
    logic             in_ctrl;
    logic             is_addr;
    logic             fend;
    logic             rend;
    logic             out_bit;

    assign cmd_chan.ready = !s1_valid_reg || bit_chan.ready;
    assign accept   = cmd_chan.valid && cmd_chan.ready;
    assign do_write = accept && (cmd_chan.cmd == CMD_WRITE)
                      && (cmd_chan.byte_index < IDX_W'(STORE_DEPTH));
    assign do_tick  = accept && (cmd_chan.cmd == CMD_TICK) && sending_reg;

    // bit position decode: d is the data bit index, e the packed bit offset
    always_comb
    begin
        is_addr  = (pos_reg < POS_W'(ADDR_BITS));
        d_full   = pos_reg - POS_W'(ADDR_BITS);
        d        = d_full[5:0];
        e        = {1'b0, d} + (frame_reg[0] ? POS_W'(4) : POS_W'(0));
        in_store = (frame_reg == 2'd3) ? (d < 6'd48) : (d < 6'd52);
        in_ctrl  = (frame_reg == 2'd0) && (d >= 6'd54) && (d <= 6'd61);
        ctrl_off = 6'd61 - d;
        rd_addr  = frame_base(frame_reg) + {1'b0, e[6:3]};
        fend     = (pos_reg == LAST_POS);
        rend     = fend && (frame_reg == 2'd3);

        s1_next.chip_enable = !is_addr;
        s1_next.frame       = frame_reg;
        s1_next.frame_end   = fend;
        s1_next.refresh_end = rend;
        s1_next.fixed_bit   = 1'b0;
        s1_next.bit_sel     = 3'd0;
        if (is_addr)
        begin
            s1_next.src       = SRC_FIXED;
            s1_next.fixed_bit = CCB_ADDRESS[~pos_reg[2:0]];
        end
        else if (in_store)
        begin
            s1_next.src     = SRC_STORE;
            s1_next.bit_sel = ~e[2:0];
        end
        else if (in_ctrl)
        begin
            s1_next.src     = SRC_CTRL;
            s1_next.bit_sel = ctrl_off[2:0];
        end
        else
        begin
            s1_next.src       = SRC_FIXED;
            s1_next.fixed_bit = tail_bit(frame_reg, d);
        end
    end

    assign rd_en = do_tick && (s1_next.src == SRC_STORE);

    // refresh sequencer
    always_comb
    begin
        sending_next = sending_reg;
        frame_next   = frame_reg;
        pos_next     = pos_reg;
        if (accept && (cmd_chan.cmd == CMD_START) && !sending_reg)
        begin
            sending_next = 1'b1;
            frame_next   = 2'd0;
            pos_next     = '0;
        end
        else if (do_tick)
        begin
            if (fend)
            begin
                pos_next = '0;
                if (rend)
                begin
                    sending_next = 1'b0;
                    frame_next   = 2'd0;
                end
                else
                begin
                    frame_next = frame_reg + 2'd1;
                end
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    assign s1_valid_next = do_tick ? 1'b1 : (bit_chan.ready ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg  <= 8'd0;
            sending_reg  <= 1'b0;
            frame_reg    <= 2'd0;
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
            vld_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                control_reg <= cfg_wr_data;
            end
            sending_reg  <= sending_next;
            frame_reg    <= frame_next;
            pos_reg      <= pos_next;
            s1_valid_reg <= s1_valid_next;
            if (do_write)
            begin
                vld_reg[cmd_chan.byte_index] <= 1'b1;
            end
        end
    end

    // store write port
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            store_mem[cmd_chan.byte_index] <= cmd_chan.byte_value;
        end
    end

    // store read port, data registered for the output stage
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_tick)
        begin
            s1_reg <= s1_next;
        end
    end

    // output stage bit select
    always_comb
    begin
        unique case (s1_reg.src)
            SRC_FIXED: out_bit = s1_reg.fixed_bit;
            SRC_STORE: out_bit = rd_vld_reg && rd_data_reg[s1_reg.bit_sel];
            SRC_CTRL:  out_bit = control_reg[s1_reg.bit_sel];
            default:   out_bit = 1'b0;
        endcase
    end

    assign bit_chan.valid        = s1_valid_reg;
    assign bit_chan.chip_enable  = s1_reg.chip_enable;
    assign bit_chan.data_bit     = out_bit;
    assign bit_chan.frame_number = s1_reg.frame;
    assign bit_chan.frame_end    = s1_reg.frame_end;
    assign bit_chan.refresh_end  = s1_reg.refresh_end;

    // checks
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("bit position past end of frame");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !sending_reg |-> (pos_reg == '0) && (frame_reg == 2'd0))
        else $error("sequencer not at frame start while idle");

    a_tick_beat: assert property (@(posedge clk) disable iff (!rst_n)
        do_tick |=> s1_valid_reg)
        else $error("tick taken without a bit beat");

    a_refresh_end: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_reg.refresh_end) |->
            (s1_reg.frame == 2'd3) && s1_reg.frame_end && s1_reg.chip_enable)
        else $error("refresh end outside last bit of frame 3");

    a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (rd_addr < IDX_W'(STORE_DEPTH)))
        else $error("store read beyond depth");

endmodule

`default_nettype wire

/* tb/segment_lcd_ccb_frame_checker.sv */
`timescale 1ns / 1ps
// checker of the frame serializer: predicts every serial bit beat and compares what comes out
module segment_lcd_ccb_frame_checker
    import lcdccb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       cmd_valid,
    input  logic       cmd_ready,
    input  logic [1:0] cmd,
    input  logic [4:0] byte_index,
    input  logic [7:0] byte_value,
    input  logic       bit_valid,
    input  logic       bit_ready,
    input  logic       chip_enable,
    input  logic       data_bit,
    input  logic [1:0] frame_number,
    input  logic       frame_end,
    input  logic       refresh_end,
    output int         fail_count,
    output int         bits_owed
);

    typedef struct packed {
        logic       chip_enable;
        logic       data_bit;
        logic [1:0] frame_number;
        logic       frame_end;
        logic       refresh_end;
    } lcd_bit_t;

    logic [7:0]       seg_bytes [STORE_DEPTH];
    logic [7:0]       ctrl_byte;
    logic             refreshing;
    logic [1:0]       frame_at;
    logic [POS_W-1:0] bit_at;
    lcd_bit_t         due_bits [$];
    int               errors = 0;

    // 64 data bits of a frame, msb first, from the store as it is now
    function automatic logic [63:0] frame_payload(input logic [1:0] f);
        logic [63:0] w;
        case (f)
            2'd0:
                w = {seg_bytes[0], seg_bytes[1], seg_bytes[2], seg_bytes[3], seg_bytes[4],
                     seg_bytes[5], seg_bytes[6][7:4], 2'b00, ctrl_byte, 2'b00};
            2'd1:
                w = {seg_bytes[6][3:0], seg_bytes[7], seg_bytes[8], seg_bytes[9],
                     seg_bytes[10], seg_bytes[11], seg_bytes[12], 8'h00, 4'h1};
            2'd2:
                w = {seg_bytes[13], seg_bytes[14], seg_bytes[15], seg_bytes[16],
                     seg_bytes[17], seg_bytes[18], seg_bytes[19][7:4], 8'h00, 4'h2};
            default:
                w = {seg_bytes[19][3:0], seg_bytes[20], seg_bytes[21], seg_bytes[22],
                     seg_bytes[23], seg_bytes[24], seg_bytes[25][7:4], 8'h00, 8'h03};
        endcase
        return w;
    endfunction

    task automatic take_command(input logic [1:0] c, input logic [4:0] idx,
                                input logic [7:0] val);
        lcd_bit_t    b;
        logic [63:0] w;
        int          p;
        case (c)
            CMD_WRITE:
                if (idx < STORE_DEPTH)
                    seg_bytes[idx] = val;
            CMD_START:
                if (!refreshing)
                begin
                    refreshing = 1'b1;
                    frame_at   = '0;
                    bit_at     = '0;
                end
            CMD_TICK:
                if (refreshing)
                begin
                    p = int'(bit_at);
                    w = frame_payload(frame_at);
                    b.chip_enable  = (p >= ADDR_BITS);
                    b.data_bit     = (p < ADDR_BITS) ? CCB_ADDRESS[7 - p] : w[71 - p];
                    b.frame_number = frame_at;
                    b.frame_end    = (bit_at == LAST_POS);
                    b.refresh_end  = b.frame_end && (frame_at == 2'd3);
                    due_bits.push_back(b);
                    if (b.frame_end)
                    begin
                        bit_at   = '0;
                        frame_at = frame_at + 2'd1;
                        if (b.refresh_end)
                            refreshing = 1'b0;
                    end
                    else
                        bit_at = bit_at + 1'b1;
                end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        lcd_bit_t got;
        lcd_bit_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
                seg_bytes[i] = '0;
            ctrl_byte  = '0;
            refreshing = 1'b0;
            frame_at   = '0;
            bit_at     = '0;
            due_bits.delete();
            fail_count <= errors;
            bits_owed  <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                ctrl_byte = cfg_wr_data;
            // outgoing beat first, so a stray beat never pairs with this edge's tick
            if (bit_valid && bit_ready)
            begin
                got = {chip_enable, data_bit, frame_number, frame_end, refresh_end};
                if (due_bits.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected bit beat, expected none, actual ce=%b d=%b fr=%0d fe=%b re=%b",
                             $time, got.chip_enable, got.data_bit, got.frame_number,
                             got.frame_end, got.refresh_end);
                end
                else
                begin
                    want = due_bits.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t: bit beat mismatch, expected ce=%b d=%b fr=%0d fe=%b re=%b, actual ce=%b d=%b fr=%0d fe=%b re=%b",
                                 $time, want.chip_enable, want.data_bit, want.frame_number,
                                 want.frame_end, want.refresh_end, got.chip_enable,
                                 got.data_bit, got.frame_number, got.frame_end,
                                 got.refresh_end);
                    end
                end
            end
            if (cmd_valid && cmd_ready)
                take_command(cmd, byte_index, byte_value);
            fail_count <= errors;
            bits_owed  <= due_bits.size();
        end
    end

endmodule

/* tb/segment_lcd_ccb_frame_serializer_tb.sv */
`timescale 1ns / 1ps
// top of the frame serializer testbench: clock, reset, command stimulus and verdict
module segment_lcd_ccb_frame_serializer_tb;

    import lcdccb_pkg::*;

    // command code the block has no use for
    localparam logic [1:0] CMD_SPARE     = 2'd3;
    localparam int         REFRESH_BITS  = 4 * FRAME_BITS;
    // the tick-to-beat path is registered, this settle wait covers it
    localparam int         SETTLE_CYCLES = 4;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   fail_count;
    int   bits_owed;

    // stimulus side view of the refresh, only used to know whether a refresh is running
    logic refresh_live;
    int   ticks_done;

    lcdccb_cmd_if cmd_if ();
    lcdccb_bit_if bit_if ();

    segment_lcd_ccb_frame_serializer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_chan    (cmd_if),
        .bit_chan    (bit_if)
    );

    segment_lcd_ccb_frame_checker checker_0 (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .cmd_valid    (cmd_if.valid),
        .cmd_ready    (cmd_if.ready),
        .cmd          (cmd_if.cmd),
        .byte_index   (cmd_if.byte_index),
        .byte_value   (cmd_if.byte_value),
        .bit_valid    (bit_if.valid),
        .bit_ready    (bit_if.ready),
        .chip_enable  (bit_if.chip_enable),
        .data_bit     (bit_if.data_bit),
        .frame_number (bit_if.frame_number),
        .frame_end    (bit_if.frame_end),
        .refresh_end  (bit_if.refresh_end),
        .fail_count   (fail_count),
        .bits_owed    (bits_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop, far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("** segment_lcd_ccb_frame_serializer: FAILED **");
        $finish;
    end

    // serial bit receiver stalls at random, at the rate of the current phase
    always @(posedge clk)
        bit_if.ready <= ($urandom_range(99) >= recv_idle_pct);

    // one command beat, with random sender gaps ahead of it; valid stays high
    // after acceptance so back-to-back beats never see a low cycle
    task automatic send_beat(input logic [1:0] c, input logic [4:0] idx,
                             input logic [7:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.cmd        <= c;
        cmd_if.byte_index <= idx;
        cmd_if.byte_value <= val;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        // track the refresh the way the block should
        if (c == CMD_START && !refresh_live)
        begin
            refresh_live = 1'b1;
            ticks_done   = 0;
        end
        else if (c == CMD_TICK && refresh_live)
        begin
            ticks_done++;
            if (ticks_done == REFRESH_BITS)
                refresh_live = 1'b0;
        end
    endtask

    // stop sending and wait until every predicted bit beat has come out
    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (bits_owed != 0);
    endtask

    // control byte is only touched with nothing in flight
    task automatic set_control(input logic [7:0] v);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // runs a refresh to its end with random store content: mostly ticks, some writes
    // landing mid-frame, ignored starts and spare commands; at most once per pass the
    // sender holds off until the output side is empty
    task automatic run_refresh_pass();
        int   pause_at;
        int   r;
        logic paused;
        pause_at = $urandom_range(REFRESH_BITS - 1, 1);
        paused   = 1'b0;
        repeat ($urandom_range(12, 4))
            send_beat(CMD_WRITE, 5'($urandom_range(31)), 8'($urandom));
        // noise while idle: a tick that gives nothing and a spare command
        if (!refresh_live)
            send_beat(CMD_TICK, 5'($urandom), 8'($urandom));
        send_beat(CMD_SPARE, 5'($urandom), 8'($urandom));
        if (!refresh_live)
            send_beat(CMD_START, 5'($urandom), 8'($urandom));
        while (refresh_live)
        begin
            r = $urandom_range(99);
            if (r < 91)
                send_beat(CMD_TICK, 5'($urandom), 8'($urandom));
            else if (r < 96)
                send_beat(CMD_WRITE, 5'($urandom_range(31)), 8'($urandom));
            else if (r < 98)
                send_beat(CMD_START, 5'($urandom), 8'($urandom));
            else
                send_beat(CMD_SPARE, 5'($urandom), 8'($urandom));
            if (!paused && ticks_done == pause_at)
            begin
                paused = 1'b1;
                drain_results();
            end
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        cmd_if.valid      = 1'b0;
        cmd_if.cmd        = CMD_WRITE;
        cmd_if.byte_index = '0;
        cmd_if.byte_value = '0;
        bit_if.ready      = 1'b0;
        refresh_live      = 1'b0;
        ticks_done        = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase 1: sender idles now and then, receiver stalls most cycles
        send_idle_pct = 12;
        recv_idle_pct = 62;
        set_control(8'hFF);

        // directed: store extremes, bytes split across frames, dropped indexes
        send_beat(CMD_WRITE, 5'd0, 8'hFF);
        send_beat(CMD_WRITE, 5'd5, 8'h00);
        send_beat(CMD_WRITE, 5'd6, 8'hA5);
        send_beat(CMD_WRITE, 5'd12, 8'hFF);
        send_beat(CMD_WRITE, 5'd19, 8'h3C);
        send_beat(CMD_WRITE, 5'd25, 8'hFF);
        send_beat(CMD_WRITE, 5'd26, 8'h77);
        send_beat(CMD_WRITE, 5'd31, 8'hFF);
        // tick while idle and the spare command: both give nothing
        send_beat(CMD_TICK, 5'd31, 8'hFF);
        send_beat(CMD_SPARE, 5'd31, 8'hFF);
        // start, then the address byte and the first data bits
        send_beat(CMD_START, 5'd0, 8'h00);
        repeat (10)
            send_beat(CMD_TICK, 5'd0, 8'h00);
        // start while busy is dropped
        send_beat(CMD_START, 5'd0, 8'h00);
        // store write mid-refresh shows up in the bits not yet sent
        send_beat(CMD_WRITE, 5'd0, 8'h00);
        repeat (3)
            send_beat(CMD_TICK, 5'd0, 8'h00);

        // finish the directed refresh with random traffic
        run_refresh_pass();

        // phase 2: sender idles a lot, receiver now and then
        send_idle_pct = 62;
        recv_idle_pct = 12;
        set_control(8'h00);
        run_refresh_pass();

        // phase 3: no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_control(8'($urandom_range(254, 1)));
        run_refresh_pass();

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && bits_owed == 0)
            $display("** segment_lcd_ccb_frame_serializer: PASSED **");
        else
            $display("** segment_lcd_ccb_frame_serializer: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/lcdccb_pkg.sv
rtl/core/lcdccb_ifs.sv
rtl/core/segment_lcd_ccb_frame_serializer.sv
tb/segment_lcd_ccb_frame_checker.sv
tb/segment_lcd_ccb_frame_serializer_tb.sv
